// ===== rtl/icr_pkg.sv =====
`timescale 1ns / 1ps

package icr_pkg;

    localparam int NUM_KW = 11;
    localparam int KW_MAXLEN = 16;
    localparam logic [6:0] MAX_FRAME = 7'd64;
    localparam logic [16:0] SILENCE_MAX = 17'h1FFFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd10;

    localparam int SUMQ_DEPTH = 2;
    localparam int SUMQ_AW = $clog2(SUMQ_DEPTH);

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    localparam logic [1:0] RULE_NEED_PARAM = 2'd0;
    localparam logic [1:0] RULE_NO_VALID_PARAM = 2'd1;
    localparam logic [1:0] RULE_NO_PARAM = 2'd2;

    localparam logic [7:0] CH_CODE_LO = 8'h5F;
    localparam logic [7:0] CH_CODE_HI = 8'h7A;
    localparam logic [7:0] CH_DIGIT_LO = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI = 8'h39;

    localparam logic [6:0] KW_LEN [0:NUM_KW-1] = '{
        7'd8, 7'd8, 7'd14, 7'd13, 7'd13, 7'd8, 7'd14, 7'd7, 7'd8, 7'd12, 7'd13
    };

    localparam logic [1:0] KW_RULE [0:NUM_KW-1] = '{
        RULE_NEED_PARAM, RULE_NEED_PARAM, RULE_NEED_PARAM, RULE_NEED_PARAM,
        RULE_NO_VALID_PARAM,
        RULE_NO_PARAM, RULE_NO_PARAM, RULE_NO_PARAM, RULE_NO_PARAM,
        RULE_NO_PARAM, RULE_NO_PARAM
    };

    localparam logic [7:0] KW_CHAR [0:NUM_KW-1][0:KW_MAXLEN-1] = '{
        '{8'h73, 8'h65, 8'h74, 8'h5F, 8'h74, 8'h69, 8'h6D, 8'h65,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h73, 8'h65, 8'h74, 8'h5F, 8'h64, 8'h61, 8'h74, 8'h65,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h73, 8'h65, 8'h74, 8'h5F, 8'h61, 8'h6C, 8'h61, 8'h72,
          8'h6D, 8'h5F, 8'h74, 8'h69, 8'h6D, 8'h65, 8'h00, 8'h00},
        '{8'h73, 8'h65, 8'h74, 8'h5F, 8'h65, 8'h73, 8'h70, 8'h5F,
          8'h6F, 8'h6E, 8'h5F, 8'h6D, 8'h73, 8'h00, 8'h00, 8'h00},
        '{8'h67, 8'h65, 8'h74, 8'h5F, 8'h65, 8'h73, 8'h70, 8'h5F,
          8'h6F, 8'h6E, 8'h5F, 8'h6D, 8'h73, 8'h00, 8'h00, 8'h00},
        '{8'h67, 8'h65, 8'h74, 8'h5F, 8'h74, 8'h69, 8'h6D, 8'h65,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h67, 8'h65, 8'h74, 8'h5F, 8'h61, 8'h6C, 8'h61, 8'h72,
          8'h6D, 8'h5F, 8'h74, 8'h69, 8'h6D, 8'h65, 8'h00, 8'h00},
        '{8'h67, 8'h65, 8'h74, 8'h5F, 8'h68, 8'h6F, 8'h74, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h67, 8'h65, 8'h74, 8'h5F, 8'h63, 8'h6F, 8'h6C, 8'h64,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h65, 8'h73, 8'h70, 8'h5F, 8'h66, 8'h6F, 8'h72, 8'h63,
          8'h65, 8'h5F, 8'h6F, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h65, 8'h73, 8'h70, 8'h5F, 8'h66, 8'h6F, 8'h72, 8'h63,
          8'h65, 8'h5F, 8'h6F, 8'h66, 8'h66, 8'h00, 8'h00, 8'h00}
    };

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  command;
        logic [31:0] parameter_res;
        logic        has_parameter;
    } t_result;

    typedef struct packed {
        logic [NUM_KW-1:0] match;
        logic              code_empty;
        logic              param_empty;
        logic              all_digits;
        logic [31:0]       value;
    } t_summary;

endpackage

// ===== rtl/icr_front.sv =====
`timescale 1ns / 1ps

module icr_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  icr_pkg::t_item        i_item,
    input  logic                  i_cfg_we,
    input  logic [15:0]           i_cfg_data,
    output logic                  o_sum_push,
    output icr_pkg::t_summary     o_sum
);

    logic [6:0]                 r_frame_count, n_frame_count;
    logic                       r_frame_active, n_frame_active;
    logic [16:0]                r_silence, n_silence;
    logic [6:0]                 r_code_len, n_code_len;
    logic                       r_in_code, n_in_code;
    logic [icr_pkg::NUM_KW-1:0] r_match, n_match;
    logic [31:0]                r_value, n_value;
    logic [6:0]                 r_param_len, n_param_len;
    logic                       r_all_digits, n_all_digits;
    logic [15:0]                r_timeout;

    logic                       ovf;
    logic [6:0]                 b_frame_count;
    logic [6:0]                 b_code_len;
    logic                       b_in_code;
    logic [icr_pkg::NUM_KW-1:0] b_match;
    logic [31:0]                b_value;
    logic [6:0]                 b_param_len;
    logic                       b_all_digits;
    logic [7:0]                 c;
    logic                       is_code;
    logic                       is_digit;
    logic [35:0]                prod;
    logic [7:0]                 digit;
    logic [16:0]                sil_inc;
    logic                       frame_end;

    always_comb begin
        c = i_item.rx_byte;
        ovf = r_frame_count >= icr_pkg::MAX_FRAME;
        b_frame_count = ovf ? 7'd0 : r_frame_count;
        b_code_len = ovf ? 7'd0 : r_code_len;
        b_in_code = ovf ? 1'b1 : r_in_code;
        b_match = ovf ? '1 : r_match;
        b_value = ovf ? 32'd0 : r_value;
        b_param_len = ovf ? 7'd0 : r_param_len;
        b_all_digits = ovf ? 1'b1 : r_all_digits;

        is_code = b_in_code && (c >= icr_pkg::CH_CODE_LO) && (c <= icr_pkg::CH_CODE_HI);
        is_digit = (c >= icr_pkg::CH_DIGIT_LO) && (c <= icr_pkg::CH_DIGIT_HI);
        digit = c - icr_pkg::CH_DIGIT_LO;
        prod = ({4'b0000, b_value} << 3) + ({4'b0000, b_value} << 1) + {32'd0, digit[3:0]};

        sil_inc = (r_silence == icr_pkg::SILENCE_MAX) ? r_silence : r_silence + 17'd1;
        frame_end = 1'b0;

        n_frame_count = r_frame_count;
        n_frame_active = r_frame_active;
        n_silence = r_silence;
        n_code_len = r_code_len;
        n_in_code = r_in_code;
        n_match = r_match;
        n_value = r_value;
        n_param_len = r_param_len;
        n_all_digits = r_all_digits;

        if (i_accept && (i_item.mode == icr_pkg::MODE_BYTE)) begin
            n_frame_active = 1'b1;
            n_silence = 17'd0;
            n_frame_count = b_frame_count + 7'd1;
            n_code_len = b_code_len;
            n_in_code = b_in_code;
            n_match = b_match;
            n_value = b_value;
            n_param_len = b_param_len;
            n_all_digits = b_all_digits;
            if (is_code) begin
                for (int k = 0; k < icr_pkg::NUM_KW; k++) begin
                    if (!((b_code_len < icr_pkg::KW_LEN[k]) &&
                          (icr_pkg::KW_CHAR[k][b_code_len[3:0]] == c))) begin
                        n_match[k] = 1'b0;
                    end
                end
                n_code_len = b_code_len + 7'd1;
            end else begin
                n_in_code = 1'b0;
                n_param_len = b_param_len + 7'd1;
                if (is_digit) begin
                    n_value = (prod[35:32] != 4'd0) ? 32'hFFFF_FFFF : prod[31:0];
                end else begin
                    n_all_digits = 1'b0;
                end
            end
        end else if (i_accept && r_frame_active) begin
            if (sil_inc > {1'b0, r_timeout}) begin
                frame_end = 1'b1;
                n_frame_count = 7'd0;
                n_frame_active = 1'b0;
                n_silence = 17'd0;
                n_code_len = 7'd0;
                n_in_code = 1'b1;
                n_match = '1;
                n_value = 32'd0;
                n_param_len = 7'd0;
                n_all_digits = 1'b1;
            end else begin
                n_silence = sil_inc;
            end
        end
    end

    always_comb begin
        o_sum_push = frame_end;
        o_sum.match = r_match;
        o_sum.code_empty = (r_code_len == 7'd0);
        o_sum.param_empty = (r_param_len == 7'd0);
        o_sum.all_digits = r_all_digits;
        o_sum.value = r_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= 7'd0;
            r_frame_active <= 1'b0;
            r_silence <= 17'd0;
            r_code_len <= 7'd0;
            r_in_code <= 1'b1;
            r_match <= '1;
            r_value <= 32'd0;
            r_param_len <= 7'd0;
            r_all_digits <= 1'b1;
            r_timeout <= icr_pkg::TIMEOUT_RESET;
        end else begin
            r_frame_count <= n_frame_count;
            r_frame_active <= n_frame_active;
            r_silence <= n_silence;
            r_code_len <= n_code_len;
            r_in_code <= n_in_code;
            r_match <= n_match;
            r_value <= n_value;
            r_param_len <= n_param_len;
            r_all_digits <= n_all_digits;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    a_frame_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_count <= icr_pkg::MAX_FRAME)
        else $error("frame count beyond limit");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_frame_active |-> (r_frame_count == 7'd0 && r_code_len == 7'd0 &&
                             r_param_len == 7'd0))
        else $error("frame state left over while no frame open");

    a_end_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sum_push |-> (i_accept && i_item.mode == icr_pkg::MODE_TICK && r_frame_active))
        else $error("frame closed without a tick");

endmodule

// ===== rtl/icr_sumq.sv =====
`timescale 1ns / 1ps

module icr_sumq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  icr_pkg::t_summary     i_data,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output icr_pkg::t_summary     o_data
);

    localparam logic [icr_pkg::SUMQ_AW:0] DEPTH = (icr_pkg::SUMQ_AW + 1)'(icr_pkg::SUMQ_DEPTH);

    icr_pkg::t_summary           r_mem [0:icr_pkg::SUMQ_DEPTH-1];
    logic [icr_pkg::SUMQ_AW-1:0] r_wptr;
    logic [icr_pkg::SUMQ_AW-1:0] r_rptr;
    logic [icr_pkg::SUMQ_AW:0]   r_count;
    logic                        do_push;
    logic                        do_pop;

    assign o_full = (r_count == DEPTH);
    assign o_valid = (r_count != '0);
    assign o_data = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10: r_count <= r_count + 1'b1;
                2'b01: r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH)
        else $error("summary queue count beyond depth");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("summary pushed into full queue");

endmodule

// ===== rtl/icr_back.sv =====
`timescale 1ns / 1ps

module icr_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_sum_valid,
    input  icr_pkg::t_summary     i_sum,
    output logic                  o_sum_pop,
    output logic                  o_valid,
    output icr_pkg::t_result      o_result,
    input  logic                  i_pop
);

    logic              r_valid;
    icr_pkg::t_result  r_result;
    icr_pkg::t_result  res;
    logic              has;
    logic              found;
    logic              rule;
    logic [3:0]        cmd;
    logic              load;

    always_comb begin
        has = !i_sum.param_empty && i_sum.all_digits;
        found = 1'b0;
        cmd = 4'd0;
        rule = 1'b0;
        for (int k = icr_pkg::NUM_KW - 1; k >= 0; k--) begin
            unique case (icr_pkg::KW_RULE[k])
                icr_pkg::RULE_NEED_PARAM: rule = has;
                icr_pkg::RULE_NO_VALID_PARAM: rule = !has;
                default: rule = i_sum.param_empty;
            endcase
            if (i_sum.match[k] && rule) begin
                found = 1'b1;
                cmd = 4'(k);
            end
        end
        if (i_sum.code_empty) begin
            res.status = icr_pkg::ST_EMPTY;
            res.command = 4'd0;
            res.parameter_res = 32'd0;
            res.has_parameter = 1'b0;
        end else begin
            res.status = found ? icr_pkg::ST_OK : icr_pkg::ST_UNKNOWN;
            res.command = found ? cmd : 4'd0;
            res.parameter_res = has ? i_sum.value : 32'd0;
            res.has_parameter = has;
        end
    end

    assign load = i_sum_valid && (!r_valid || i_pop);
    assign o_sum_pop = load;
    assign o_valid = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// ===== rtl/idle_framed_command_recognizer_unit.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Transfer when            | Payload
// ---------+-----------+--------------------------+---------------------------
// item     | in        | push && !full            | i_item   (mode, rx_byte)
// result   | out       | pop && !empty            | o_result (status, command,
//          |           |                          |           parameter_res,
//          |           |                          |           has_parameter)
// cfg      | in        | i_cfg_valid && o_cfg_ready | i_cfg_data (idle timeout)
//
// One item per cycle while full is low; the frame parser updates match flags and the decimal
// accumulator in the cycle of the item.
// After the closing tick, a result passes through the summary queue and then the
// output register before it appears on the result ports.
// full rises only when the two-entry summary queue is full; that happens
// only while the result side is not popped.
// Reset is synchronous and active low; the idle timeout returns to 10 ticks.

module idle_framed_command_recognizer_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  icr_pkg::t_item        i_item,
    output logic                  empty,
    input  logic                  pop,
    output icr_pkg::t_result      o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [15:0]           i_cfg_data
);

    logic              accept;
    logic              sum_push;
    icr_pkg::t_summary sum_in;
    logic              q_valid;
    icr_pkg::t_summary q_data;
    logic              q_pop;
    logic              out_valid;

    assign accept = push && !full;
    assign o_cfg_ready = 1'b1;
    assign empty = !out_valid;

    icr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_sum_push (sum_push),
        .o_sum      (sum_in)
    );

    icr_sumq u_sumq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (sum_push),
        .i_data  (sum_in),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    icr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sum_valid (q_valid),
        .i_sum       (q_data),
        .o_sum_pop   (q_pop),
        .o_valid     (out_valid),
        .o_result    (o_result),
        .i_pop       (pop)
    );

endmodule

// ===== test/idle_framed_command_recognizer_unit_tb.sv =====
`timescale 1ns / 1ps

module idle_framed_command_recognizer_unit_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int LAST_NEED_PARAM_KW = 3;
    localparam int OPT_PARAM_KW = 4;
    localparam int KW_SET_CLK = 0;
    localparam int KW_SET_DAY = 1;
    localparam int KW_SET_WAKE = 2;
    localparam int KW_READ_CLK = 5;
    localparam int KW_READ_COOL = 8;
    localparam int KW_FORCE_A = 9;
    localparam int KW_FORCE_B = 10;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    icr_pkg::t_item   i_item = '0;
    logic             empty;
    logic             pop = 1'b0;
    icr_pkg::t_result o_result;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [15:0]      i_cfg_data = '0;

    idle_framed_command_recognizer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    icr_pkg::t_result           expected_reports [$];
    int unsigned                timeout_ticks = icr_pkg::TIMEOUT_RESET;
    int                         frame_bytes;
    bit                         frame_open;
    logic [16:0]                quiet_ticks;
    int                         code_len;
    bit                         in_code_part;
    logic [icr_pkg::NUM_KW-1:0] kw_alive;
    logic [31:0]                param_acc;
    int                         param_len;
    bit                         param_digits;

    int send_idle_pct = 11;
    int recv_idle_pct = 54;
    int hold_request = 0;
    int items_sent = 0;
    int error_count = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic string kw_text(input int k);
        string s;
        s = "";
        for (int i = 0; i < int'(icr_pkg::KW_LEN[k]); i++)
            s = $sformatf("%s%c", s, icr_pkg::KW_CHAR[k][i]);
        return s;
    endfunction

    function automatic void clear_frame_state();
        frame_bytes = 0;
        frame_open = 1'b0;
        quiet_ticks = '0;
        code_len = 0;
        in_code_part = 1'b1;
        kw_alive = '1;
        param_acc = '0;
        param_len = 0;
        param_digits = 1'b1;
    endfunction

    function automatic void predict_frame_item(input icr_pkg::t_item it);
        icr_pkg::t_result rpt;
        logic [35:0]      wide;
        logic             has;
        bit               rule_ok;
        if (it.mode == icr_pkg::MODE_BYTE) begin
            if (frame_bytes >= icr_pkg::MAX_FRAME) clear_frame_state();
            frame_open = 1'b1;
            quiet_ticks = '0;
            frame_bytes++;
            if (in_code_part && it.rx_byte >= icr_pkg::CH_CODE_LO &&
                it.rx_byte <= icr_pkg::CH_CODE_HI) begin
                for (int k = 0; k < icr_pkg::NUM_KW; k++) begin
                    if (code_len >= int'(icr_pkg::KW_LEN[k]) ||
                        icr_pkg::KW_CHAR[k][code_len % icr_pkg::KW_MAXLEN] != it.rx_byte)
                        kw_alive[k] = 1'b0;
                end
                code_len++;
            end else begin
                in_code_part = 1'b0;
                param_len++;
                if (it.rx_byte >= icr_pkg::CH_DIGIT_LO && it.rx_byte <= icr_pkg::CH_DIGIT_HI) begin
                    wide = 36'(param_acc) * 36'd10 + 36'(it.rx_byte - icr_pkg::CH_DIGIT_LO);
                    param_acc = (wide > 36'hFFFFFFFF) ? 32'hFFFFFFFF : wide[31:0];
                end else begin
                    param_digits = 1'b0;
                end
            end
        end else if (frame_open) begin
            if (quiet_ticks < icr_pkg::SILENCE_MAX) quiet_ticks++;
            if (quiet_ticks > timeout_ticks) begin
                has = (param_len > 0) && param_digits;
                rpt.status = icr_pkg::ST_UNKNOWN;
                rpt.command = '0;
                rpt.parameter_res = has ? param_acc : 32'd0;
                rpt.has_parameter = has;
                if (code_len == 0) begin
                    rpt.status = icr_pkg::ST_EMPTY;
                    rpt.parameter_res = '0;
                    rpt.has_parameter = 1'b0;
                end else begin
                    for (int k = 0; k < icr_pkg::NUM_KW; k++) begin
                        if (kw_alive[k] && rpt.status == icr_pkg::ST_UNKNOWN) begin
                            if (k <= LAST_NEED_PARAM_KW) rule_ok = has;
                            else if (k == OPT_PARAM_KW) rule_ok = !has;
                            else rule_ok = (param_len == 0);
                            if (rule_ok) begin
                                rpt.status = icr_pkg::ST_OK;
                                rpt.command = 4'(k);
                            end
                        end
                    end
                end
                expected_reports.push_back(rpt);
                clear_frame_state();
            end
        end
    endfunction

    function automatic void check_report(input icr_pkg::t_result got);
        icr_pkg::t_result want;
        if (expected_reports.size() == 0) begin
            $error("unexpected result: status %0d command %0d parameter_res %0d",
                   got.status, got.command, got.parameter_res);
            error_count++;
        end else begin
            want = expected_reports.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                error_count++;
            end
            if (got.command !== want.command) begin
                $error("command: expected %0d, got %0d", want.command, got.command);
                error_count++;
            end
            if (got.parameter_res !== want.parameter_res) begin
                $error("parameter_res: expected %0d, got %0d",
                       want.parameter_res, got.parameter_res);
                error_count++;
            end
            if (got.has_parameter !== want.has_parameter) begin
                $error("has_parameter: expected %0d, got %0d",
                       want.has_parameter, got.has_parameter);
                error_count++;
            end
        end
    endfunction

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) check_report(o_result);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        int stalled_cycles;
        stalled_cycles = 0;
        while (stalled_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (push && !full) || (pop && !empty)) stalled_cycles = 0;
            else stalled_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_item(input logic item_mode, input logic [7:0] value);
        icr_pkg::t_item it;
        it.mode = item_mode;
        it.rx_byte = value;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_frame_item(it);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(icr_pkg::MODE_BYTE, s[i]);
    endtask

    task automatic send_ticks(input int n);
        for (int i = 0; i < n; i++) send_item(icr_pkg::MODE_TICK, 8'($urandom_range(255)));
    endtask

    task automatic close_frame();
        send_ticks(timeout_ticks + 1);
    endtask

    task automatic send_frame(input string s);
        send_text(s);
        close_frame();
    endtask

    task automatic write_idle_timeout(input logic [15:0] value);
        push <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        timeout_ticks = value;
    endtask

    task automatic send_random_frame();
        int         pick;
        int         cut;
        int         n;
        string      kw;
        logic [7:0] ch;
        pick = $urandom_range(99);
        if (pick < 78) begin
            kw = kw_text($urandom_range(icr_pkg::NUM_KW - 1));
            cut = ($urandom_range(4) == 0) ? $urandom_range(kw.len()) : kw.len();
            for (int i = 0; i < cut; i++) begin
                ch = kw[i];
                if ($urandom_range(24) == 0)
                    ch = icr_pkg::CH_CODE_LO +
                         8'($urandom_range(icr_pkg::CH_CODE_HI - icr_pkg::CH_CODE_LO));
                send_item(icr_pkg::MODE_BYTE, ch);
                if (timeout_ticks > 0 && $urandom_range(9) == 0)
                    send_ticks($urandom_range(timeout_ticks));
            end
            case ($urandom_range(3))
                1, 2: begin
                    n = ($urandom_range(7) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 6);
                    for (int i = 0; i < n; i++)
                        send_item(icr_pkg::MODE_BYTE, icr_pkg::CH_DIGIT_LO + 8'($urandom_range(9)));
                end
                3: begin
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++)
                        send_item(icr_pkg::MODE_BYTE, 8'($urandom_range(255)));
                end
                default: ;
            endcase
        end else if (pick < 97) begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) send_item(icr_pkg::MODE_BYTE, 8'($urandom_range(255)));
        end else begin
            n = icr_pkg::MAX_FRAME + $urandom_range(1, 16);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(1) == 0)
                    ch = icr_pkg::CH_CODE_LO +
                         8'($urandom_range(icr_pkg::CH_CODE_HI - icr_pkg::CH_CODE_LO));
                else
                    ch = 8'($urandom_range(255));
                send_item(icr_pkg::MODE_BYTE, ch);
            end
        end
        send_ticks(timeout_ticks + 1 + (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0));
    endtask

    task automatic test_reset_timeout();
        send_ticks(3);
        send_text("get_hot");
        send_ticks(10);
        send_text("1");
        send_ticks(11);
        send_frame("get_hot");
    endtask

    task automatic test_special_frames();
        write_idle_timeout(16'd0);
        send_frame({kw_text(KW_SET_CLK), "42"});
        send_frame(kw_text(KW_SET_CLK));
        send_frame(kw_text(OPT_PARAM_KW));
        send_frame({kw_text(OPT_PARAM_KW), "7"});
        send_frame({kw_text(OPT_PARAM_KW), "=on"});
        send_frame("se");
        send_frame("e");
        send_frame(kw_text(KW_FORCE_B));
        send_frame("123");
        send_frame({kw_text(KW_SET_DAY), "4294967296"});
        send_frame({kw_text(KW_SET_WAKE), "99999999999"});
        send_frame({kw_text(KW_SET_WAKE), "36000000001"});
        send_text({kw_text(KW_SET_CLK), "1"});
        send_item(icr_pkg::MODE_BYTE, 8'h00);
        close_frame();
        send_item(icr_pkg::MODE_BYTE, 8'hFF);
        close_frame();
        send_frame("_zz9");
        for (int i = 0; i < icr_pkg::MAX_FRAME; i++) send_item(icr_pkg::MODE_BYTE, "a");
        send_frame("get_hot");
    endtask

    task automatic test_timeout_extremes();
        write_idle_timeout(16'hFFFF);
        send_text(kw_text(KW_READ_CLK));
        send_ticks(300);
        write_idle_timeout(16'd1);
        send_ticks(1);
        send_text(kw_text(KW_FORCE_A));
        send_ticks(1);
        send_text("5");
        close_frame();
    endtask

    task automatic test_random_frames(input int target, input logic [15:0] timeout_value);
        int first;
        write_idle_timeout(timeout_value);
        first = items_sent;
        while (items_sent - first < target) send_random_frame();
    endtask

    task automatic test_backpressure();
        write_idle_timeout(16'd0);
        hold_request = HOLD_OFF_CYCLES;
        repeat (20) send_frame(kw_text(KW_READ_COOL));
    endtask

    initial begin
        clear_frame_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_timeout();
        test_special_frames();
        test_timeout_extremes();
        test_random_frames(130, 16'($urandom_range(3)));

        send_idle_pct = 54;
        recv_idle_pct = 11;
        test_random_frames(130, 16'($urandom_range(1, 6)));

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_frames(110, 16'($urandom_range(2)));
        test_backpressure();

        push <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES * 4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
